### hdl/msf_pkg.sv
// ----------------------------------------------------------------------------
// msf_pkg
// Shared types, codes and helpers of the message frame splitter.
// ----------------------------------------------------------------------------
package msf_pkg;

	// byte count and offset width, set by the 17-bit buffer_bytes field
	localparam int OffW = 17;
	// sums of offset and message size need two more bits
	localparam int SumW = OffW + 2;

	// register indexes on the configuration port
	localparam logic [1:0] REG_BYTE_SWAP = 2'd0;
	localparam logic [1:0] REG_EXT_MASK  = 2'd1;
	localparam logic [1:0] REG_OP_MASK   = 2'd2;

	// result kinds
	typedef enum logic [1:0] {
		KIND_DESC  = 2'd0,
		KIND_ERROR = 2'd1,
		KIND_DONE  = 2'd2
	} kind_t;

	// parse phases, one-hot
	typedef enum logic [2:0] {
		PH_HEADER = 3'b001,
		PH_EXT    = 3'b010,
		PH_BODY   = 3'b100
	} phase_t;

	typedef struct packed {
		logic        byte_swap;
		logic [15:0] ext_mask;
		logic [15:0] op_mask;
	} cfg_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] message_type;
		logic [15:0] reply_id;
		logic [15:0] payload_bytes;
		logic [17:0] header_bytes;
		logic [16:0] body_offset;
		logic        run_end;
	} result_t;

	// up to two results produced by one word
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} push_t;

	typedef struct packed {
		phase_t           phase;
		logic [OffW-1:0]  byte_off;
		logic [OffW-1:0]  buf_size;
		logic [15:0]      words_left;
		logic [15:0]      held_op;
		logic [15:0]      held_words;
		logic             stopped;
	} parse_state_t;

	// 16-bit field read, big-endian when swap is set
	function automatic logic [15:0] half(input logic [15:0] v, input logic swap);
		half = swap ? {v[7:0], v[15:8]} : v;
	endfunction

endpackage

### hdl/msf_word_if.sv
// ----------------------------------------------------------------------------
// msf_word_if
// Input channel: one buffer word per item.
// ----------------------------------------------------------------------------
interface msf_word_if;
	logic        valid;
	logic        ready;
	logic        first_word;
	logic [16:0] buffer_bytes;
	logic [31:0] data_word;

	modport source (output valid, first_word, buffer_bytes, data_word, input ready);
	modport sink (input valid, first_word, buffer_bytes, data_word, output ready);
endinterface

### hdl/msf_result_if.sv
// ----------------------------------------------------------------------------
// msf_result_if
// Output channel: one descriptor, error or done result per item.
// ----------------------------------------------------------------------------
interface msf_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] message_type;
	logic [15:0] reply_id;
	logic [15:0] payload_bytes;
	logic [17:0] header_bytes;
	logic [16:0] body_offset;
	logic        run_end;

	modport source (output valid, kind, message_type, reply_id, payload_bytes,
		header_bytes, body_offset, run_end, input ready);
	modport sink (input valid, kind, message_type, reply_id, payload_bytes,
		header_bytes, body_offset, run_end, output ready);
endinterface

### hdl/msf_cfg_regs.sv
// ----------------------------------------------------------------------------
// msf_cfg_regs
// APB-style register file: byte swap, extension flag mask, opcode mask.
// ----------------------------------------------------------------------------
module msf_cfg_regs import msf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.byte_swap <= 1'b0;
			cfg_q.ext_mask  <= 16'h8000;
			cfg_q.op_mask   <= 16'h7FFF;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_BYTE_SWAP: cfg_q.byte_swap <= pwdata[0];
				REG_EXT_MASK:  cfg_q.ext_mask  <= pwdata[15:0];
				REG_OP_MASK:   cfg_q.op_mask   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		unique case (paddr[3:2])
			REG_BYTE_SWAP: prdata = {31'd0, cfg_q.byte_swap};
			REG_EXT_MASK:  prdata = {16'd0, cfg_q.ext_mask};
			REG_OP_MASK:   prdata = {16'd0, cfg_q.op_mask};
			default:       prdata = 32'd0;
		endcase
	end

endmodule

### hdl/msf_parser.sv
// ----------------------------------------------------------------------------
// msf_parser
// Input register, parse state and the per-word header/extension/body step.
// ----------------------------------------------------------------------------
module msf_parser import msf_pkg::*; #(
	parameter int MAX_BUFFER_BYTES = 65536
) (
	input  logic         clk,
	input  logic         arst_n,
	msf_word_if.sink     words,
	input  cfg_t         cfg,
	input  logic         room,
	output push_t        push
);

	localparam logic [20:0] MaxBytes = 21'(MAX_BUFFER_BYTES);

	logic            valid_s1;
	logic            first_s1;
	logic [16:0]     bytes_s1;
	logic [31:0]     data_s1;
	logic            adv;

	parse_state_t    state_q;
	parse_state_t    st;
	parse_state_t    nxt;

	logic [OffW-1:0] sat_size;
	logic [15:0]     lo_half;
	logic [15:0]     hi_half;
	logic [SumW-1:0] off4;
	logic [SumW-1:0] size_ext;
	logic [15:0]     fin_op;
	logic [15:0]     fin_words;
	logic [15:0]     fin_pay;
	logic [15:0]     fin_rid;
	logic [17:0]     fin_body;
	logic [17:0]     fin_hdr;
	logic [SumW-1:0] fin_end;
	logic            fin_bad;
	result_t         res_err;
	result_t         res_done;
	result_t         res_desc;
	result_t         r0;
	result_t         r1;
	logic [1:0]      n;

	assign adv         = valid_s1 & room;
	assign words.ready = ~valid_s1 | adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (words.ready) begin
			valid_s1 <= words.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (words.ready && words.valid) begin
			first_s1 <= words.first_word;
			bytes_s1 <= words.buffer_bytes;
			data_s1  <= words.data_word;
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase      <= PH_HEADER;
			state_q.byte_off   <= '0;
			state_q.buf_size   <= '0;
			state_q.words_left <= '0;
			state_q.held_op    <= '0;
			state_q.held_words <= '0;
			state_q.stopped    <= 1'b1;
		end else if (adv) begin
			state_q <= nxt;
		end
	end

	// buffer start: saturate count and restart
	always_comb begin
		sat_size = ({4'd0, bytes_s1} > MaxBytes) ? MaxBytes[OffW-1:0] : bytes_s1;
		st = state_q;
		if (first_s1) begin
			st.buf_size   = sat_size;
			st.byte_off   = '0;
			st.words_left = '0;
			st.phase      = PH_HEADER;
			st.stopped    = 1'b0;
		end
	end

	// shared message checks for header and extension words
	always_comb begin
		lo_half  = half(data_s1[15:0], cfg.byte_swap);
		hi_half  = half(data_s1[31:16], cfg.byte_swap);
		off4     = {2'd0, st.byte_off} + SumW'(4);
		size_ext = {2'd0, st.buf_size};
		if (st.phase == PH_EXT) begin
			fin_op    = st.held_op;
			fin_words = st.held_words;
			fin_pay   = lo_half;
			fin_rid   = hi_half;
		end else begin
			fin_op    = lo_half;
			fin_words = hi_half;
			fin_pay   = 16'd0;
			fin_rid   = 16'd0;
		end
		fin_body = {fin_words, 2'b00};
		fin_end  = off4 + {1'b0, fin_body};
		fin_bad  = (fin_end > size_ext) || ({2'd0, fin_pay} > fin_body);
		fin_hdr  = (fin_body - {2'd0, fin_pay}) & ~18'd3;
	end

	// result templates
	always_comb begin
		res_err  = '0;
		res_err.kind = KIND_ERROR;
		res_done = '0;
		res_done.kind = KIND_DONE;
		res_desc.kind          = KIND_DESC;
		res_desc.message_type  = fin_op & cfg.op_mask;
		res_desc.reply_id      = fin_rid;
		res_desc.payload_bytes = fin_pay;
		res_desc.header_bytes  = fin_hdr;
		res_desc.body_offset   = off4[OffW-1:0];
		res_desc.run_end       = 1'b0;
	end

	// per-word step
	always_comb begin
		nxt = st;
		r0  = res_done;
		r1  = res_done;
		n   = 2'd0;
		if (first_s1 && sat_size == '0) begin
			r0 = res_done;
			n  = 2'd1;
			nxt.stopped = 1'b1;
		end else if (!st.stopped) begin
			if (st.phase == PH_BODY) begin
				if (st.words_left != 16'd0) begin
					nxt.words_left = st.words_left - 16'd1;
				end
				if (st.words_left <= 16'd1) begin
					nxt.phase = PH_HEADER;
					if (st.byte_off >= st.buf_size) begin
						r0 = res_done;
						n  = 2'd1;
						nxt.stopped = 1'b1;
					end
				end
			end else if (st.phase != PH_EXT && (lo_half & cfg.ext_mask) != 16'd0) begin
				// flagged header: extension word must fit
				if (off4 + SumW'(4) > size_ext) begin
					r0 = res_err;
					n  = 2'd1;
					nxt.stopped = 1'b1;
					nxt.phase   = PH_HEADER;
				end else begin
					nxt.held_op    = lo_half;
					nxt.held_words = hi_half;
					nxt.byte_off   = off4[OffW-1:0];
					nxt.phase      = PH_EXT;
				end
			end else if (fin_bad) begin
				r0 = res_err;
				n  = 2'd1;
				nxt.stopped = 1'b1;
				nxt.phase   = PH_HEADER;
			end else begin
				// descriptor, then body count or done
				r0 = res_desc;
				n  = 2'd1;
				nxt.byte_off   = fin_end[OffW-1:0];
				nxt.words_left = fin_words;
				nxt.held_op    = fin_op;
				nxt.held_words = fin_words;
				if (fin_words == 16'd0) begin
					nxt.phase = PH_HEADER;
					if (fin_end >= size_ext) begin
						r1 = res_done;
						n  = 2'd2;
						nxt.stopped = 1'b1;
					end
				end else begin
					nxt.phase = PH_BODY;
				end
			end
		end
		if (n == 2'd2) begin
			r1.run_end = 1'b1;
		end else begin
			r0.run_end = 1'b1;
		end
	end

	assign push.count = adv ? n : 2'd0;
	assign push.r0    = r0;
	assign push.r1    = r1;

endmodule

### hdl/msf_result_fifo.sv
// ----------------------------------------------------------------------------
// msf_result_fifo
// Four-entry result queue taking up to two results a cycle, giving one.
// ----------------------------------------------------------------------------
module msf_result_fifo import msf_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  push_t         push,
	output logic          room,
	msf_result_if.source  results
);

	result_t    mem [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] count_q;
	logic       pop;
	result_t    head;

	assign room = count_q <= 3'd2;
	assign pop  = results.valid & results.ready;
	assign head = mem[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push.count;
			rd_ptr_q <= rd_ptr_q + {1'b0, pop};
			count_q  <= 3'(count_q + {1'b0, push.count} - {2'd0, pop});
		end
	end

	// entry writes
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem[wr_ptr_q] <= push.r0;
		end
		if (push.count == 2'd2) begin
			mem[wr_ptr_q + 2'd1] <= push.r1;
		end
	end

	assign results.valid         = count_q != 3'd0;
	assign results.kind          = head.kind;
	assign results.message_type  = head.message_type;
	assign results.reply_id      = head.reply_id;
	assign results.payload_bytes = head.payload_bytes;
	assign results.header_bytes  = head.header_bytes;
	assign results.body_offset   = head.body_offset;
	assign results.run_end       = head.run_end;

endmodule

### hdl/message_frame_splitter_core.sv
// ----------------------------------------------------------------------------
// message_frame_splitter_core
// Deframes length-prefixed messages from a stream of 32-bit buffer words.
// ----------------------------------------------------------------------------
// path: a word's results pass the input register and the result queue before the output
// throughput: one word per cycle while the result queue has room; the parse step is combinational
// a word with two results (descriptor plus done) gives them at the output one at a time
// reset: parser idles until a first word, result queue empties,
// registers return to no swap, flag mask 0x8000, opcode mask 0x7fff
module message_frame_splitter_core import msf_pkg::*; #(
	parameter int MAX_BUFFER_BYTES = 65536
) (
	input  logic         clk,
	input  logic         arst_n,
	msf_word_if.sink     words,
	msf_result_if.source results,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	cfg_t  cfg;
	push_t push;
	logic  room;

	// configuration registers
	msf_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// word parser
	msf_parser #(
		.MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.words  (words),
		.cfg    (cfg),
		.room   (room),
		.push   (push)
	);

	// result queue
	msf_result_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.room    (room),
		.results (results)
	);

endmodule
